>>> rtl/tspq_pkg.sv
// Package for the telemetry slot pool queue: word types, request and status codes,
// slot phases and the command structs passed between the top level and its units.
// No dependencies.
package tspq_pkg;

    // Input word: one request.
    typedef struct packed {
        logic [2:0] req_type;
        logic       req_class;
        logic [4:0] slot_index;
        logic       slot_present;
    } t_req;

    // Output word: one result per request.
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  result_slot;
        logic        result_class;
        logic        slot_freed;
        logic [15:0] drops_seen;
    } t_rsp;

    // Request types
    localparam logic [2:0] REQ_RESERVE    = 3'd0;
    localparam logic [2:0] REQ_DISMISS    = 3'd1;
    localparam logic [2:0] REQ_COMMIT     = 3'd2;
    localparam logic [2:0] REQ_CONS_BEGIN = 3'd3;
    localparam logic [2:0] REQ_CONS_END   = 3'd4;
    localparam logic [2:0] REQ_ACK        = 3'd5;

    // Result status
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Slot phases
    localparam logic [1:0] PH_FREE     = 2'd0;
    localparam logic [1:0] PH_RESERVED = 2'd1;
    localparam logic [1:0] PH_QUEUED   = 2'd2;

    // Slot table update for one request
    typedef struct packed {
        logic reserve;       // take slot, one reference, record class
        logic release_slot;  // back to the free pool
        logic enqueue;       // mark queued
        logic ref_inc;
        logic ref_dec;
        logic kind;
    } t_slot_cmd;

    // Class queue update for one request
    typedef struct packed {
        logic push;
        logic pop;
        logic cls;
    } t_queue_cmd;

endpackage

>>> rtl/tspq_slots.sv
// Slot table of the telemetry slot pool queue: phase, class, reference count and free
// map per slot, plus the lowest-free-slot search. Depends on tspq_pkg.
module tspq_slots #(
    parameter int TOTAL_SLOTS  = 30,
    parameter int URGENT_SLOTS = 10,
    parameter int REF_BITS     = 4,
    parameter int SLOT_W       = $clog2(TOTAL_SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tspq_pkg::t_slot_cmd   i_cmd,
    input  logic [SLOT_W-1:0]     i_wr_addr,
    input  logic [SLOT_W-1:0]     i_rd_addr,
    input  logic                  i_search_cls,
    output logic [1:0]            o_rd_phase,
    output logic                  o_rd_kind,
    output logic [REF_BITS-1:0]   o_rd_refs,
    output logic                  o_found,
    output logic [SLOT_W-1:0]     o_found_idx
);
    import tspq_pkg::*;

    logic [1:0]          r_phase [TOTAL_SLOTS];
    logic                r_kind  [TOTAL_SLOTS];
    logic [REF_BITS-1:0] r_refs  [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] r_free;

    assign o_rd_phase = r_phase[i_rd_addr];
    assign o_rd_kind  = r_kind[i_rd_addr];
    assign o_rd_refs  = r_refs[i_rd_addr];

    // Lowest free slot; a nonurgent search skips the urgent range.
    always_comb begin
        o_found     = 1'b0;
        o_found_idx = '0;
        for (int i = TOTAL_SLOTS - 1; i >= 0; i--) begin
            if (r_free[i] && (!i_search_cls || i >= URGENT_SLOTS)) begin
                o_found     = 1'b1;
                o_found_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOTAL_SLOTS; i++) begin
                r_phase[i] <= PH_FREE;
                r_kind[i]  <= 1'b0;
                r_refs[i]  <= '0;
            end
            r_free <= '1;
        end else begin
            if (i_cmd.reserve) begin
                r_phase[i_wr_addr] <= PH_RESERVED;
                r_kind[i_wr_addr]  <= i_cmd.kind;
                r_refs[i_wr_addr]  <= REF_BITS'(1);
                r_free[i_wr_addr]  <= 1'b0;
            end
            if (i_cmd.release_slot) begin
                r_phase[i_wr_addr] <= PH_FREE;
                r_refs[i_wr_addr]  <= '0;
                r_free[i_wr_addr]  <= 1'b1;
            end
            if (i_cmd.enqueue) begin
                r_phase[i_wr_addr] <= PH_QUEUED;
            end
            if (i_cmd.ref_inc) begin
                r_refs[i_wr_addr] <= r_refs[i_wr_addr] + REF_BITS'(1);
            end
            if (i_cmd.ref_dec) begin
                r_refs[i_wr_addr] <= r_refs[i_wr_addr] - REF_BITS'(1);
            end
        end
    end

endmodule

>>> rtl/tspq_queues.sv
// Class queues of the telemetry slot pool queue: head, tail and nonempty flag per class
// and the link store that chains committed slots. Depends on tspq_pkg.
module tspq_queues #(
    parameter int TOTAL_SLOTS = 30,
    parameter int SLOT_W      = $clog2(TOTAL_SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tspq_pkg::t_queue_cmd  i_cmd,
    input  logic [SLOT_W-1:0]     i_slot,
    output logic [SLOT_W-1:0]     o_head [2],
    output logic                  o_nonempty [2]
);
    import tspq_pkg::*;

    logic [SLOT_W-1:0] r_head [2];
    logic [SLOT_W-1:0] r_tail [2];
    logic              r_ne   [2];
    logic [SLOT_W-1:0] r_link [TOTAL_SLOTS];
    logic [SLOT_W-1:0] link_next;

    assign o_head     = r_head;
    assign o_nonempty = r_ne;
    assign link_next  = r_link[r_head[i_cmd.cls]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_ne[c]   <= 1'b0;
            end
        end else begin
            if (i_cmd.push) begin
                if (!r_ne[i_cmd.cls]) begin
                    r_head[i_cmd.cls] <= i_slot;
                end
                r_tail[i_cmd.cls] <= i_slot;
                r_ne[i_cmd.cls]   <= 1'b1;
            end
            if (i_cmd.pop) begin
                if (r_head[i_cmd.cls] == r_tail[i_cmd.cls]) begin
                    r_ne[i_cmd.cls] <= 1'b0;
                end else begin
                    r_head[i_cmd.cls] <= link_next;
                end
            end
        end
    end

    // Link the new slot behind the current tail.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_ne[i_cmd.cls]) begin
            r_link[r_tail[i_cmd.cls]] <= i_slot;
        end
    end

endmodule

>>> rtl/telemetry_slot_pool_queue_top.sv
// Top level of the telemetry slot pool queue: request register, request decode,
// drop tally and result register. Depends on tspq_pkg, tspq_slots, tspq_queues.
//
// Usage:
//   Request channel: drive a request word on i_req and raise start. The word is
//   taken at the rising edge where start is high and busy is low. busy stays low,
//   so a request may be issued in every cycle.
//   Result channel: every request yields exactly one result word on o_rsp, marked
//   by o_done for exactly one cycle. The receiver cannot stall; a result not
//   captured in its cycle is gone.
// Request flow:
//   A taken request is held in the request register and decoded against the slot
//   table and the class queues; its result is captured in the result register.
//   One request per cycle. The state updates land at the same edge as the
//   result, so a following request already sees them.
// Reset (synchronous, active low):
//   All slots free with zero references, both queues empty, drop tally zero, no
//   result pending. The queue link store is not cleared; a link is only followed
//   after it was written.
// Decode cost per request: one priority search over the pool, one read of a slot
// entry and one head compare.
module telemetry_slot_pool_queue_top #(
    parameter int URGENT_SLOTS    = 10,
    parameter int NONURGENT_SLOTS = 20,
    parameter int REF_BITS        = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tspq_pkg::t_req i_req,
    output logic           o_done,
    output tspq_pkg::t_rsp o_rsp
);
    import tspq_pkg::*;

    localparam int TOTAL_SLOTS = URGENT_SLOTS + NONURGENT_SLOTS;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
    localparam logic [6:0]          TOTAL_V = 7'(TOTAL_SLOTS);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    // Request stage
    logic r_req_v;
    t_req r_req;

    // Result stage
    logic r_done;
    t_rsp r_rsp;
    logic [15:0] r_drops;
    logic [15:0] n_drops;
    t_rsp        n_rsp;

    // Decode signals
    logic [5:0]          s_ext;
    logic                s_valid;
    logic [SLOT_W-1:0]   s_idx;
    logic [SLOT_W-1:0]   rd_addr;
    logic [SLOT_W-1:0]   wr_addr;
    logic [1:0]          rd_phase;
    logic                rd_kind;
    logic [REF_BITS-1:0] rd_refs;
    logic [REF_BITS-1:0] refs_dec;
    logic                found;
    logic [SLOT_W-1:0]   found_idx;
    logic [SLOT_W-1:0]   q_head [2];
    logic                q_ne   [2];
    logic                rel_cls;
    logic                is_head;
    t_slot_cmd           scmd;
    t_queue_cmd          qcmd;

    // busy is tied low: the block never stalls a request and never holds start off.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v <= 1'b0;
        end else begin
            r_req_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    // Slot handle: beyond the pool means an invalid handle.
    assign s_ext   = {1'b0, r_req.slot_index};
    assign s_valid = {1'b0, s_ext} < TOTAL_V;
    assign s_idx   = s_ext[SLOT_W-1:0];

    // Consume-begin reads the queue head, everything else the given handle.
    assign rd_addr = (r_req.req_type == REQ_CONS_BEGIN) ? q_head[r_req.req_class] : s_idx;
    assign wr_addr = (r_req.req_type == REQ_RESERVE) ? found_idx : rd_addr;

    // Ack names its class; consume-end uses the class the slot was reserved in.
    assign rel_cls  = (r_req.req_type == REQ_ACK) ? r_req.req_class : rd_kind;
    assign is_head  = s_valid && q_ne[rel_cls] && (q_head[rel_cls] == s_idx)
                      && (rd_phase == PH_QUEUED);
    assign refs_dec = rd_refs - REF_BITS'(1);

    always_comb begin
        scmd    = '0;
        qcmd    = '0;
        n_drops = r_drops;
        n_rsp   = '0;
        n_rsp.status = ST_DONE;
        unique case (r_req.req_type)
            REQ_RESERVE: begin
                if (!found) begin
                    n_rsp.status = ST_NONE;
                    if (r_drops != 16'hFFFF) begin
                        n_drops = r_drops + 16'd1;
                    end
                end else begin
                    scmd.reserve        = 1'b1;
                    scmd.kind           = r_req.req_class;
                    n_rsp.result_slot   = 5'((6)'(found_idx));
                    n_rsp.result_class  = r_req.req_class;
                end
            end
            REQ_DISMISS: begin
                if (!s_valid || rd_phase != PH_RESERVED) begin
                    n_rsp.status = ST_ERROR;
                end else begin
                    scmd.release_slot = 1'b1;
                    n_rsp.slot_freed  = 1'b1;
                end
            end
            REQ_COMMIT: begin
                if (!s_valid || rd_phase != PH_RESERVED) begin
                    n_rsp.status = ST_ERROR;
                end else begin
                    scmd.enqueue = 1'b1;
                    qcmd.push    = 1'b1;
                    qcmd.cls     = rd_kind;
                end
            end
            REQ_CONS_BEGIN: begin
                if (!q_ne[r_req.req_class]) begin
                    n_rsp.status = ST_NONE;
                end else if (rd_refs == REF_MAX) begin
                    n_rsp.status = ST_ERROR;
                end else begin
                    scmd.ref_inc       = 1'b1;
                    n_rsp.result_slot  = 5'((6)'(rd_addr));
                    n_rsp.result_class = rd_kind;
                end
            end
            REQ_CONS_END, REQ_ACK: begin
                if (r_req.req_type == REQ_ACK && (!r_req.slot_present || !is_head)) begin
                    n_rsp.status = ST_IGNORED;
                end else if (!is_head) begin
                    n_rsp.status = ST_ERROR;
                end else if (refs_dec != '0) begin
                    scmd.ref_dec = 1'b1;
                end else begin
                    // Last reference gone: free the slot and pop its queue.
                    scmd.release_slot = 1'b1;
                    qcmd.pop          = 1'b1;
                    qcmd.cls          = rel_cls;
                    n_rsp.slot_freed  = 1'b1;
                end
            end
            default: begin
                n_rsp.status = ST_ERROR;
            end
        endcase
        // Drop everything when no request is in the stage.
        if (!r_req_v) begin
            scmd    = '0;
            qcmd    = '0;
            n_drops = r_drops;
        end
        n_rsp.drops_seen = n_drops;
    end

    tspq_slots #(
        .TOTAL_SLOTS  (TOTAL_SLOTS),
        .URGENT_SLOTS (URGENT_SLOTS),
        .REF_BITS     (REF_BITS),
        .SLOT_W       (SLOT_W)
    ) u_slots (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (scmd),
        .i_wr_addr    (wr_addr),
        .i_rd_addr    (rd_addr),
        .i_search_cls (r_req.req_class),
        .o_rd_phase   (rd_phase),
        .o_rd_kind    (rd_kind),
        .o_rd_refs    (rd_refs),
        .o_found      (found),
        .o_found_idx  (found_idx)
    );

    tspq_queues #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_queues (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (qcmd),
        .i_slot     (s_idx),
        .o_head     (q_head),
        .o_nonempty (q_ne)
    );

    // Result register and drop tally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_drops <= '0;
        end else begin
            r_done  <= r_req_v;
            r_drops <= n_drops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_v) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
